FILE: src/lbb_pkg.sv
// Shared types, constants and helpers for the label bounding box unit.
package lbb_pkg;

    localparam int MAX_LABELS_DEF = 4096;
    localparam int MAX_DIM        = 4096;

    localparam int KIND_W      = 2;
    localparam int LABEL_W     = 12;
    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int CFG_INDEX_W = 1;

    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LABEL_W-1:0] label;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0]   min_x;
        logic [COORD_W-1:0] max_x;
        logic [DIM_W-1:0]   min_y;
        logic [COORD_W-1:0] max_y;
        logic [LABEL_W-1:0] highest_label;
        logic               label_seen;
    } result_t;

    // One word of the box memory; the seen flag lives beside the box.
    typedef struct packed {
        logic               seen;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_y;
    } box_entry_t;

    localparam int ENTRY_W = $bits(box_entry_t);

    typedef struct packed {
        logic take_pixel;
        logic take_query;
        logic begin_clear;
        logic clearing;
        logic pix_write;
        logic qry_capture;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pix_update;
        logic clear_done;
    } dp_status_t;

    // Effective frame size: at least one, at most MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: src/lbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/lbb_ctrl.sv
// Controller: sequences pixel updates, queries and the memory clearing pass.
module lbb_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lbb_pkg::KIND_W-1:0] kind,
    input  lbb_pkg::dp_status_t        status,
    output logic                       busy,
    output lbb_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PIX_WR,
        ST_QRY_RD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        cmd             = '0;
        cmd.take_pixel  = accept && (kind == lbb_pkg::KIND_PIXEL);
        cmd.take_query  = accept && (kind == lbb_pkg::KIND_QUERY);
        cmd.begin_clear = accept && (kind == lbb_pkg::KIND_START);
        cmd.clearing    = (state_reg == ST_CLEAR);
        cmd.pix_write   = (state_reg == ST_PIX_WR);
        cmd.qry_capture = (state_reg == ST_QRY_RD);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Background, out-of-frame pixels and unknown kinds never leave idle.
                priority if (cmd.take_pixel && status.pix_update)
                    state_next = ST_PIX_WR;
                else if (cmd.take_query)
                    state_next = ST_QRY_RD;
                else if (cmd.begin_clear)
                    state_next = ST_CLEAR;
                else
                    state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (status.clear_done)
                    state_next = ST_IDLE;
            end
            ST_PIX_WR: state_next = ST_IDLE;
            ST_QRY_RD: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Reset starts with a full clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/lbb_datapath.sv
// Datapath: frame registers, raster counters, box memory and result register.
module lbb_datapath #(
    parameter int MAX_LABELS = lbb_pkg::MAX_LABELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lbb_pkg::ctrl_cmd_t              cmd,
    input  logic [lbb_pkg::LABEL_W-1:0]     label,
    input  logic                            cfg_write,
    input  logic [lbb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbb_pkg::DIM_W-1:0]       cfg_data,
    output lbb_pkg::dp_status_t             status,
    output lbb_pkg::result_t                result,
    output logic                            result_valid
);

    localparam int LW = $clog2(MAX_LABELS);

    logic [lbb_pkg::DIM_W-1:0]   frame_width_reg;
    logic [lbb_pkg::DIM_W-1:0]   frame_height_reg;
    logic [lbb_pkg::COORD_W-1:0] column_reg;
    logic [lbb_pkg::DIM_W-1:0]   row_reg;
    logic [lbb_pkg::LABEL_W-1:0] highest_reg;
    logic [LW-1:0]               clear_cnt_reg;

    logic [LW-1:0]               pix_addr_reg;
    logic [lbb_pkg::COORD_W-1:0] pix_x_reg;
    logic [lbb_pkg::COORD_W-1:0] pix_y_reg;
    logic                        qry_in_range_reg;

    lbb_pkg::result_t            result_reg;
    lbb_pkg::result_t            result_next;
    logic                        result_valid_reg;

    logic [lbb_pkg::DIM_W-1:0]   w_eff;
    logic [lbb_pkg::DIM_W-1:0]   h_eff;
    logic                        frame_active;
    logic                        label_in_range;
    logic [lbb_pkg::DIM_W-1:0]   column_inc;

    logic                        ram_wr_en;
    logic [LW-1:0]               ram_wr_addr;
    lbb_pkg::box_entry_t         ram_wr_data;
    lbb_pkg::box_entry_t         ram_rd_data;
    lbb_pkg::box_entry_t         box_next;

    assign w_eff          = lbb_pkg::clamp_dim(frame_width_reg);
    assign h_eff          = lbb_pkg::clamp_dim(frame_height_reg);
    assign frame_active   = (row_reg < h_eff);
    assign label_in_range = (32'(label) < MAX_LABELS);
    assign column_inc     = {1'b0, column_reg} + lbb_pkg::DIM_W'(1);

    assign status.pix_update = frame_active && (label != '0) && label_in_range;
    assign status.clear_done = (clear_cnt_reg == LW'(MAX_LABELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lbb_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= lbb_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lbb_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                lbb_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            highest_reg   <= '0;
            clear_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.begin_clear)
            begin
                column_reg    <= '0;
                row_reg       <= '0;
                highest_reg   <= '0;
                clear_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.clearing)
                begin
                    clear_cnt_reg <= clear_cnt_reg + LW'(1);
                end
                if (cmd.take_pixel && frame_active)
                begin
                    // Wrap to the next row at the end of a line.
                    if (column_inc >= w_eff)
                    begin
                        column_reg <= '0;
                        row_reg    <= row_reg + lbb_pkg::DIM_W'(1);
                    end
                    else
                    begin
                        column_reg <= column_inc[lbb_pkg::COORD_W-1:0];
                    end
                    if (status.pix_update && (label > highest_reg))
                    begin
                        highest_reg <= label;
                    end
                end
            end
        end
    end

    // Hold the pixel position and address for the write-back cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.take_pixel)
        begin
            pix_addr_reg <= LW'(label);
            pix_x_reg    <= column_reg;
            pix_y_reg    <= row_reg[lbb_pkg::COORD_W-1:0];
        end
        if (cmd.take_query)
        begin
            qry_in_range_reg <= label_in_range;
        end
    end

    always_comb
    begin
        box_next = ram_rd_data;
        if (!ram_rd_data.seen)
        begin
            box_next.seen  = 1'b1;
            box_next.min_x = pix_x_reg;
            box_next.max_x = pix_x_reg;
            box_next.min_y = pix_y_reg;
            box_next.max_y = pix_y_reg;
        end
        else
        begin
            if (pix_x_reg < ram_rd_data.min_x) box_next.min_x = pix_x_reg;
            if (pix_x_reg > ram_rd_data.max_x) box_next.max_x = pix_x_reg;
            if (pix_y_reg < ram_rd_data.min_y) box_next.min_y = pix_y_reg;
            if (pix_y_reg > ram_rd_data.max_y) box_next.max_y = pix_y_reg;
        end
    end

    always_comb
    begin
        ram_wr_en   = cmd.clearing || cmd.pix_write;
        ram_wr_addr = cmd.clearing ? clear_cnt_reg : pix_addr_reg;
        ram_wr_data = cmd.clearing ? '0 : box_next;
    end

    lbb_ram #(
        .WIDTH (lbb_pkg::ENTRY_W),
        .DEPTH (MAX_LABELS)
    ) u_box_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.take_pixel || cmd.take_query),
        .rd_addr (LW'(label)),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        result_next.highest_label = highest_reg;
        result_next.label_seen    = qry_in_range_reg && ram_rd_data.seen;
        if (result_next.label_seen)
        begin
            result_next.min_x = {1'b0, ram_rd_data.min_x};
            result_next.max_x = ram_rd_data.max_x;
            result_next.min_y = {1'b0, ram_rd_data.min_y};
            result_next.max_y = ram_rd_data.max_y;
        end
        else
        begin
            result_next.min_x = w_eff;
            result_next.max_x = '0;
            result_next.min_y = h_eff;
            result_next.max_y = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.qry_capture)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.qry_capture;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

FILE: src/label_bounding_box_unit.sv
// Top level: bounding boxes of labeled regions in a raster label stream.
// Pixel needing a box update: busy for 1 cycle after the accept (read, then write back).
// Background, out-of-frame pixels and unknown kinds: busy stays low, next item at once.
// Query: read, then QRY_RD registers result and result_valid; busy for 1 cycle.
// Start: busy while the box memory is cleared, one entry a cycle.
// Reset: same clearing pass; frame size returns to 640 x 480.
module label_bounding_box_unit #(
    parameter int MAX_LABELS = lbb_pkg::MAX_LABELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  lbb_pkg::item_t                  item,
    output lbb_pkg::result_t                result,
    output logic                            result_valid,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lbb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbb_pkg::DIM_W-1:0]       cfg_data
);

    lbb_pkg::ctrl_cmd_t  cmd;
    lbb_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    lbb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    lbb_datapath #(
        .MAX_LABELS (MAX_LABELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .label        (item.label),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

FILE: src/lbb_checker.sv
// Port-level checks for the label bounding box unit, bound to the top level.
module lbb_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input lbb_pkg::item_t   item,
    input lbb_pkg::result_t result,
    input logic             result_valid
);

    logic query_accept;
    logic start_accept;

    assign query_accept = start && !busy && (item.kind == lbb_pkg::KIND_QUERY);
    assign start_accept = start && !busy && (item.kind == lbb_pkg::KIND_START);

    // Every result answers an earlier accepted query transaction.
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(query_accept, 2))
        else $error("result without a matching query");

    a_query_answered: assert property (@(posedge clk) disable iff (!rst_n)
        query_accept |-> ##2 result_valid)
        else $error("query not answered");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_accept |=> busy)
        else $error("no clearing pass after start");

    a_unseen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.label_seen) |-> (result.max_x == '0 && result.max_y == '0))
        else $error("unseen label with nonzero maxima");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.label_seen) |->
            (result.min_x <= {1'b0, result.max_x} && result.min_y <= {1'b0, result.max_y}))
        else $error("box minimum above maximum");

endmodule

bind label_bounding_box_unit lbb_checker u_lbb_checker (.*);

FILE: tb/tb_label_bounding_box_unit.sv
// Self-checking testbench for the label bounding box unit: driver, monitor and box predictor.
module tb_label_bounding_box_unit;
    import lbb_pkg::*;

    localparam int                N_LABELS     = MAX_LABELS_DEF;
    localparam int                ITEM_TARGET  = 1250;
    localparam int                SETTLE_CYCLES = MAX_LABELS_DEF + 16;
    localparam int                CYCLE_LIMIT  = 2_000_000;
    localparam int                REPORT_CAP   = 200;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    typedef struct {
        int lo_x;
        int hi_x;
        int lo_y;
        int hi_y;
    } box_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    item_t                  item = '0;
    result_t                result;
    logic                   result_valid;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;

    // Predictor state
    logic [DIM_W-1:0] width_reg = FRAME_WIDTH_RST;
    logic [DIM_W-1:0] height_reg = FRAME_HEIGHT_RST;
    int               col_pos = 0;
    int               row_pos = 0;
    int               top_label = 0;
    box_t             boxes [N_LABELS];
    bit               marked [N_LABELS];
    result_t          boxes_due [$];

    // Stimulus and bookkeeping
    item_t pending [$];
    bit    took = 1'b0;
    bit    no_gaps = 1'b0;
    int    gap_left = 0;
    int    n_pushed = 0;
    int    n_accepted = 0;
    int    n_pixels = 0;
    int    n_starts = 0;
    int    n_checked = 0;
    int    n_cfg = 0;
    int    errors = 0;
    int    cycles = 0;

    label_bounding_box_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        int r;
        r = int'(v);
        if (r < 1)
            r = 1;
        else if (r > MAX_DIM)
            r = MAX_DIM;
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(input int lim);
        if ($urandom_range(0, 99) < 85)
            return DIM_W'($urandom_range(1, lim));
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DIM_W'(1);
            2: return DIM_W'(MAX_DIM);
            3: return DIM_W'(MAX_DIM + 1);
            4: return '1;
            default: return DIM_W'($urandom_range(13, 8191));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= REPORT_CAP)
            $display("mismatch %s at query %0d: got %0d, expected %0d",
                     what, n_checked, got, want);
    endtask

    // Track one accepted transaction; queries queue their expected box.
    task automatic track_item(input item_t it);
        int      w;
        int      h;
        int      x;
        int      y;
        int      lab;
        bit      hit;
        result_t r;
        lab = int'(it.label);
        case (it.kind)
            KIND_PIXEL:
            begin
                w = eff_dim(width_reg);
                h = eff_dim(height_reg);
                x = col_pos;
                y = row_pos;
                if (y < h)
                begin
                    n_pixels++;
                    if (lab > 0 && lab < N_LABELS)
                    begin
                        if (lab > top_label)
                            top_label = lab;
                        if (!marked[lab])
                        begin
                            marked[lab] = 1'b1;
                            boxes[lab] = '{x, x, y, y};
                        end
                        else
                        begin
                            if (x < boxes[lab].lo_x) boxes[lab].lo_x = x;
                            if (x > boxes[lab].hi_x) boxes[lab].hi_x = x;
                            if (y < boxes[lab].lo_y) boxes[lab].lo_y = y;
                            if (y > boxes[lab].hi_y) boxes[lab].hi_y = y;
                        end
                    end
                    // wrap when the column reaches the current width
                    if (x + 1 >= w)
                    begin
                        col_pos = 0;
                        row_pos = y + 1;
                    end
                    else
                        col_pos = x + 1;
                end
            end
            KIND_START:
            begin
                n_starts++;
                foreach (marked[i])
                    marked[i] = 1'b0;
                col_pos = 0;
                row_pos = 0;
                top_label = 0;
            end
            KIND_QUERY:
            begin
                hit = lab < N_LABELS && marked[lab];
                if (hit)
                begin
                    r.min_x = DIM_W'(boxes[lab].lo_x);
                    r.max_x = COORD_W'(boxes[lab].hi_x);
                    r.min_y = DIM_W'(boxes[lab].lo_y);
                    r.max_y = COORD_W'(boxes[lab].hi_y);
                end
                else
                begin
                    r.min_x = DIM_W'(eff_dim(width_reg));
                    r.max_x = '0;
                    r.min_y = DIM_W'(eff_dim(height_reg));
                    r.max_y = '0;
                end
                r.highest_label = LABEL_W'(top_label);
                r.label_seen = hit;
                boxes_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        n_checked++;
        if (boxes_due.size() == 0)
            report_mismatch("result with no query outstanding", 1, 0);
        else
        begin
            want = boxes_due.pop_front();
            if (got.min_x !== want.min_x)
                report_mismatch("min_x", int'(got.min_x), int'(want.min_x));
            if (got.max_x !== want.max_x)
                report_mismatch("max_x", int'(got.max_x), int'(want.max_x));
            if (got.min_y !== want.min_y)
                report_mismatch("min_y", int'(got.min_y), int'(want.min_y));
            if (got.max_y !== want.max_y)
                report_mismatch("max_y", int'(got.max_y), int'(want.max_y));
            if (got.highest_label !== want.highest_label)
                report_mismatch("highest_label", int'(got.highest_label),
                                int'(want.highest_label));
            if (got.label_seen !== want.label_seen)
                report_mismatch("label_seen", int'(got.label_seen), int'(want.label_seen));
        end
    endtask

    // Monitor: sample results, accepted items and register writes
    always @(posedge clk)
    begin
        if (!rst_n)
            took = 1'b0;
        else
        begin
            if (result_valid)
                check_result(result);
            took = start && !busy;
            if (took)
            begin
                track_item(item);
                n_accepted++;
            end
            if (cfg_valid && cfg_ready)
            begin
                n_cfg++;
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
        end
    end

    // Driver: hold an item until accepted, then idle or advance
    always @(negedge clk)
    begin
        item_t nxt;
        bit    go;
        if (!rst_n)
        begin
            gap_left = 0;
            start <= 1'b0;
        end
        else if (!start || took)
        begin
            go = 1'b0;
            nxt = item;
            if (gap_left > 0)
                gap_left--;
            else if (pending.size() > 0)
            begin
                nxt = pending.pop_front();
                go = 1'b1;
                gap_left = gap_len();
            end
            start <= go;
            item <= nxt;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d queries outstanding",
                     cycles, boxes_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push(input logic [KIND_W-1:0] k, input int lab);
        item_t it;
        it.kind = k;
        it.label = LABEL_W'(lab);
        pending.push_back(it);
        n_pushed++;
    endtask

    // Wait until all items are taken and all results are in; optionally let clearing finish.
    task automatic wait_idle(input bit settle);
        while (n_accepted != n_pushed || boxes_due.size() != 0)
            @(negedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int               counted;
        int               n;
        int               area;
        int               np;
        int               r;
        bit               first;
        logic [DIM_W-1:0] gen_w;
        logic [DIM_W-1:0] gen_h;
        int               palette [$];

        foreach (marked[i])
            marked[i] = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values: nothing seen, 640 x 480
        push(KIND_QUERY, 0);
        wait_idle(1'b1);

        // Full 3 x 2 frame with extreme labels, overrun pixel and an unknown kind
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        push(KIND_START, 0);
        push(KIND_QUERY, 0);
        push(KIND_PIXEL, 4095);
        push(KIND_PIXEL, 0);
        push(KIND_PIXEL, 1);
        push(KIND_PIXEL, 1);
        push(KIND_PIXEL, 4095);
        push(KIND_PIXEL, 7);
        push(KIND_PIXEL, 5);
        push(KIND_UNUSED, 4095);
        push(KIND_QUERY, 4095);
        push(KIND_QUERY, 1);
        push(KIND_QUERY, 5);
        wait_idle(1'b1);

        // Out-of-range sizes clamp: width to the maximum, height of zero to one
        write_reg(REG_FRAME_WIDTH, 13'd8191);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        push(KIND_QUERY, 2);
        push(KIND_PIXEL, 2);
        push(KIND_START, 0);
        push(KIND_PIXEL, 2);
        push(KIND_PIXEL, 3);
        push(KIND_QUERY, 3);
        wait_idle(1'b1);

        // Narrow the width mid-frame: the column past the new width wraps next pixel
        write_reg(REG_FRAME_WIDTH, 13'd8);
        write_reg(REG_FRAME_HEIGHT, 13'd4096);
        push(KIND_START, 0);
        repeat (4) push(KIND_PIXEL, 9);
        wait_idle(1'b1);
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'd4097);
        push(KIND_PIXEL, 9);
        push(KIND_PIXEL, 9);
        push(KIND_QUERY, 9);
        push(KIND_QUERY, 6);

        gen_w = 13'd2;
        gen_h = 13'd4097;
        counted = n_pushed;
        first = 1'b1;
        while (counted < ITEM_TARGET)
        begin
            if (first || $urandom_range(0, 9) < 4)
            begin
                wait_idle(1'b1);
                r = $urandom_range(0, 2);
                if (r != 1)
                begin
                    gen_w = pick_dim(12);
                    write_reg(REG_FRAME_WIDTH, gen_w);
                end
                if (r != 0)
                begin
                    gen_h = pick_dim(8);
                    write_reg(REG_FRAME_HEIGHT, gen_h);
                end
            end
            first = 1'b0;
            no_gaps = ($urandom_range(0, 3) == 0);
            // mostly a fresh frame; otherwise continue the current one
            if ($urandom_range(0, 9) < 8)
            begin
                push(KIND_START, 0);
                counted++;
            end
            np = $urandom_range(1, 5);
            palette.delete();
            repeat (np)
            begin
                case ($urandom_range(0, 3))
                    0: palette.push_back($urandom_range(1, 15));
                    1: palette.push_back(4095);
                    default: palette.push_back($urandom_range(1, 4095));
                endcase
            end
            area = eff_dim(gen_w) * eff_dim(gen_h);
            if (area <= 160)
                n = area + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            else
                n = $urandom_range(8, 48);
            counted += (n < area) ? n : area;
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    push(KIND_PIXEL, 0);
                else if (r < 90)
                    push(KIND_PIXEL, palette[$urandom_range(0, np - 1)]);
                else
                    push(KIND_PIXEL, $urandom_range(0, 4095));
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        push(KIND_QUERY, palette[$urandom_range(0, np - 1)]);
                    else if (r < 85)
                        push(KIND_QUERY, $urandom_range(0, 4095));
                    else
                        push(KIND_QUERY, ($urandom_range(0, 1) == 0) ? 0 : 4095);
                    counted++;
                end
                else if (r < 15)
                    push(KIND_UNUSED, $urandom_range(0, 4095));
                else if (r == 15 && $urandom_range(0, 3) == 0)
                begin
                    // broken frame: restart in the middle of the stream
                    push(KIND_START, 0);
                    counted++;
                end
            end
            foreach (palette[i])
                push(KIND_QUERY, palette[i]);
            counted += np;
        end

        wait_idle(1'b1);
        $display("covered %0d transactions: %0d in-frame pixels, %0d queries, %0d frame starts",
                 n_accepted, n_pixels, n_checked, n_starts);
        $display("%0d register writes, %0d mismatches", n_cfg, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
src/lbb_pkg.sv
src/lbb_ram.sv
src/lbb_ctrl.sv
src/lbb_datapath.sv
src/label_bounding_box_unit.sv
src/lbb_checker.sv
tb/tb_label_bounding_box_unit.sv
